FILE: sv/lbe_pkg.sv
// Shared types, constants and helpers for the label boundary edge extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lbe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int LABEL_BITS = 32;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CFGW_W = 11;
    localparam int ROW_W  = 16;
    localparam int ROWC_W = ROW_W + 1;
    localparam int CRD_W  = 32;
    localparam int SP_W   = 31;
    localparam int PX_W   = SP_W + WCNT_W;
    localparam int PY_W   = SP_W + ROWC_W;
    localparam int SUM_W  = PY_W + 2;
    localparam int NKIND  = 6;

    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        EK_INT_V  = 3'd0,
        EK_INT_H  = 3'd1,
        EK_LEFT   = 3'd2,
        EK_RIGHT  = 3'd3,
        EK_BOTTOM = 3'd4,
        EK_TOP    = 3'd5
    } edge_kind_t;

    typedef enum logic [2:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_ORIGIN_X = 3'd2,
        CFG_ORIGIN_Y = 3'd3,
        CFG_SPACE_X  = 3'd4,
        CFG_SPACE_Y  = 3'd5,
        CFG_Z        = 3'd6,
        CFG_OUTLINE  = 3'd7
    } cfg_idx_t;

    typedef logic [NKIND-1:0] kind_mask_t;

    typedef struct packed {
        logic [CFGW_W-1:0]       width;
        logic [ROW_W-1:0]        height;
        logic signed [CRD_W-1:0] origin_x;
        logic signed [CRD_W-1:0] origin_y;
        logic [SP_W-1:0]         spacing_x;
        logic [SP_W-1:0]         spacing_y;
        logic signed [CRD_W-1:0] z_value;
        logic                    outline;
    } cfg_t;

    // pixel position and pending segment flags after the line buffer stage
    typedef struct packed {
        logic                  valid;
        logic [COL_W-1:0]      x;
        logic [WCNT_W-1:0]     x1;
        logic [ROW_W-1:0]      y;
        logic [ROWC_W-1:0]     y1;
        kind_mask_t            kflags;
        logic [LABEL_BITS-1:0] label;
    } front_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] cx0;
        logic signed [CRD_W-1:0] cx1;
        logic signed [CRD_W-1:0] cy0;
        logic signed [CRD_W-1:0] cy1;
        kind_mask_t              mask;
    } seg_t;

    // origin + product, saturated to the signed 32-bit range
    function automatic logic signed [CRD_W-1:0] sat_coord(
        input logic signed [CRD_W-1:0] org,
        input logic [PY_W-1:0]         prod
    );
        logic [SUM_W-1:0] s;
        s = {{(SUM_W-CRD_W){org[CRD_W-1]}}, org} + {{(SUM_W-PY_W){1'b0}}, prod};
        if (s[SUM_W-1:CRD_W-1] == '0 || s[SUM_W-1:CRD_W-1] == '1) begin
            sat_coord = s[CRD_W-1:0];
        end else if (s[SUM_W-1]) begin
            sat_coord = {1'b1, {(CRD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(CRD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/lbe_front.sv
// Position counters, left label register and previous-row line buffer.
// Produces the registered pixel position and boundary flags; uses lbe_pkg.
`default_nettype none

module lbe_front import lbe_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [LABEL_BITS-1:0] label_in,
    input  wire cfg_t                  cfg,
    output front_t                     s1,
    output logic [LABEL_BITS-1:0]      up_label
);

    logic [LABEL_BITS-1:0] line_mem [MAX_WIDTH];

    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [LABEL_BITS-1:0] left_reg;
    logic [LABEL_BITS-1:0] up_reg;
    front_t                s1_reg, s1_next;

    logic [WCNT_W-1:0] w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [COL_W-1:0]  x;
    logic [WCNT_W-1:0] x1;
    logic [ROW_W-1:0]  y;
    logic [ROWC_W-1:0] y1;

    always_comb begin
        if (cfg.width == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(cfg.width) > MAX_WIDTH) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(cfg.width);
        end
        h_eff = (cfg.height == '0) ? ROW_W'(1) : cfg.height;
        x  = (WCNT_W'(col_reg) < w_eff) ? col_reg : COL_W'(w_eff - WCNT_W'(1));
        x1 = WCNT_W'(x) + WCNT_W'(1);
        y  = (row_reg < h_eff) ? row_reg : h_eff - ROW_W'(1);
        y1 = ROWC_W'(y) + ROWC_W'(1);

        if (x1 >= w_eff) begin
            col_next = '0;
            row_next = (y1 >= ROWC_W'(h_eff)) ? '0 : y1[ROW_W-1:0];
        end else begin
            col_next = x1[COL_W-1:0];
            row_next = y;
        end

        s1_next.valid     = accept;
        s1_next.x         = x;
        s1_next.x1        = x1;
        s1_next.y         = y;
        s1_next.y1        = y1;
        s1_next.label     = label_in;
        s1_next.kflags[0] = (x != '0) && (left_reg != label_in);
        s1_next.kflags[1] = (y != '0);
        s1_next.kflags[2] = cfg.outline && (x == '0);
        s1_next.kflags[3] = cfg.outline && (x1 == w_eff);
        s1_next.kflags[4] = cfg.outline && (y == '0);
        s1_next.kflags[5] = cfg.outline && (y1 == ROWC_W'(h_eff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= label_in;
        end
    end

    // read-first: the old row's label comes out while the new one goes in
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_mem[x] <= label_in;
            up_reg      <= line_mem[x];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else begin
            s1_reg.valid <= s1_next.valid;
        end
        s1_reg.x      <= s1_next.x;
        s1_reg.x1     <= s1_next.x1;
        s1_reg.y      <= s1_next.y;
        s1_reg.y1     <= s1_next.y1;
        s1_reg.kflags <= s1_next.kflags;
        s1_reg.label  <= s1_next.label;
    end

    assign s1       = s1_reg;
    assign up_label = up_reg;

endmodule

`default_nettype wire

FILE: sv/lbe_coord.sv
// Segment mask and endpoint coordinates: multiply stage, then origin add with saturation.
// Feeds the segment queue; uses lbe_pkg.
`default_nettype none

module lbe_coord import lbe_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire front_t                s1,
    input  wire logic [LABEL_BITS-1:0] up_label,
    input  wire cfg_t                  cfg,
    output logic                       s2_valid,
    output logic                       push,
    output seg_t                       push_seg
);

    logic              valid_reg;
    kind_mask_t        mask_reg, mask_next;
    logic [PX_W-1:0]   px0_reg, px1_reg;
    logic [PY_W-1:0]   py0_reg, py1_reg;

    always_comb begin
        mask_next    = s1.kflags;
        mask_next[1] = s1.kflags[1] && (up_label != s1.label);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= s1.valid;
        end
        mask_reg <= mask_next;
        px0_reg  <= PX_W'(s1.x) * PX_W'(cfg.spacing_x);
        px1_reg  <= PX_W'(s1.x1) * PX_W'(cfg.spacing_x);
        py0_reg  <= PY_W'(s1.y) * PY_W'(cfg.spacing_y);
        py1_reg  <= PY_W'(s1.y1) * PY_W'(cfg.spacing_y);
    end

    always_comb begin
        push_seg.cx0  = sat_coord(cfg.origin_x, PY_W'(px0_reg));
        push_seg.cx1  = sat_coord(cfg.origin_x, PY_W'(px1_reg));
        push_seg.cy0  = sat_coord(cfg.origin_y, py0_reg);
        push_seg.cy1  = sat_coord(cfg.origin_y, py1_reg);
        push_seg.mask = mask_reg;
    end

    assign s2_valid = valid_reg;
    assign push     = valid_reg && (mask_reg != '0);

endmodule

`default_nettype wire

FILE: sv/lbe_seg_queue.sv
// Pixel queue and serializer: one entry per pushed pixel, one segment per output request.
// Uses lbe_pkg; fed by lbe_coord.
`default_nettype none

module lbe_seg_queue import lbe_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire seg_t                push_seg,
    input  wire logic                out_ready,
    output logic [FCNT_W-1:0]        fill,
    output logic                     out_valid,
    output logic signed [CRD_W-1:0]  out_sx,
    output logic signed [CRD_W-1:0]  out_sy,
    output logic signed [CRD_W-1:0]  out_ex,
    output logic signed [CRD_W-1:0]  out_ey,
    output edge_kind_t               out_kind,
    output logic                     out_last
);

    seg_t fifo_mem [FIFO_DEPTH];

    logic [FPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0]       fill_reg, fill_next;
    kind_mask_t              sent_reg;
    logic                    out_valid_reg;
    logic signed [CRD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    edge_kind_t              kind_reg;
    logic                    last_reg;

    seg_t                    head;
    kind_mask_t              remaining;
    kind_mask_t              pick_bit;
    logic [2:0]              pick;
    edge_kind_t              pick_kind;
    logic                    pick_last;
    logic                    load;
    logic                    pop;
    logic signed [CRD_W-1:0] sx, sy, ex, ey;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_seg;
        end
    end

    always_comb begin
        head      = fifo_mem[rd_ptr_reg];
        remaining = head.mask & ~sent_reg;
        pick      = 3'd0;
        for (int i = NKIND - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                pick = 3'(i);
            end
        end
        pick_bit  = kind_mask_t'(1) << pick;
        pick_last = (remaining & ~pick_bit) == '0;
        pick_kind = edge_kind_t'(pick);
        load      = (fill_reg != '0) && (!out_valid_reg || out_ready);
        pop       = load && pick_last;
        fill_next = fill_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    always_comb begin
        case (pick_kind)
            EK_INT_V, EK_LEFT: begin
                sx = head.cx0; sy = head.cy0; ex = head.cx0; ey = head.cy1;
            end
            EK_INT_H, EK_BOTTOM: begin
                sx = head.cx0; sy = head.cy0; ex = head.cx1; ey = head.cy0;
            end
            EK_RIGHT: begin
                sx = head.cx1; sy = head.cy0; ex = head.cx1; ey = head.cy1;
            end
            EK_TOP: begin
                sx = head.cx0; sy = head.cy1; ex = head.cx1; ey = head.cy1;
            end
            default: begin
                sx = head.cx0; sy = head.cy0; ex = head.cx0; ey = head.cy1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FPTR_W'(1);
                sent_reg   <= '0;
            end else if (load) begin
                sent_reg <= sent_reg | pick_bit;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sx_reg   <= sx;
            sy_reg   <= sy;
            ex_reg   <= ex;
            ey_reg   <= ey;
            kind_reg <= pick_kind;
            last_reg <= pick_last;
        end
    end

    assign fill      = fill_reg;
    assign out_valid = out_valid_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
    assign out_ex    = ex_reg;
    assign out_ey    = ey_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("segment queue fill above depth");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fill_reg < FCNT_W'(FIFO_DEPTH)) || pop)
        else $error("segment queue overrun");

    a_load_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> remaining != '0)
        else $error("queue entry with no segment left");

    a_sent_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> sent_reg == '0)
        else $error("sent mask not cleared after pop");

endmodule

`default_nettype wire

FILE: sv/label_boundary_edge_extractor_core.sv
// Pixel labels arrive one request per cycle in raster order; each pixel yields zero to
// four boundary segments, delivered one per output request from a queue of eight pixels.
// A pixel is accepted every cycle as long as its segments drain at one per cycle; a pixel
// with n segments holds the result port for n transfers. Its segments pass the line
// buffer read, multiply, origin add, queue and output register. The line buffer holds
// no reset state and needs no clearing pass. Configuration writes are taken at any time
// and must only be issued while the block is idle.
`default_nettype none

module label_boundary_edge_extractor_core import lbe_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [31:0]           s_feature_label,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [CRD_W-1:0]    m_start_x,
    output logic signed [CRD_W-1:0]    m_start_y,
    output logic signed [CRD_W-1:0]    m_end_x,
    output logic signed [CRD_W-1:0]    m_end_y,
    output logic signed [CRD_W-1:0]    m_plane_z,
    output logic [2:0]                 m_edge_kind,
    output logic                       m_last_of_pixel,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);

    cfg_t        cfg_reg;
    logic        accept;
    front_t      s1;
    logic [LABEL_BITS-1:0] up_label;
    logic        s2_valid;
    logic        push;
    seg_t        push_seg;
    logic [FCNT_W-1:0] fill;
    logic [FCNT_W:0]   pending;
    edge_kind_t  out_kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width     <= CFGW_W'(1);
            cfg_reg.height    <= ROW_W'(1);
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.spacing_x <= SP_W'(65536);
            cfg_reg.spacing_y <= SP_W'(65536);
            cfg_reg.z_value   <= '0;
            cfg_reg.outline   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:    cfg_reg.width     <= cfg_data[CFGW_W-1:0];
                CFG_HEIGHT:   cfg_reg.height    <= cfg_data[ROW_W-1:0];
                CFG_ORIGIN_X: cfg_reg.origin_x  <= cfg_data;
                CFG_ORIGIN_Y: cfg_reg.origin_y  <= cfg_data;
                CFG_SPACE_X:  cfg_reg.spacing_x <= cfg_data[SP_W-1:0];
                CFG_SPACE_Y:  cfg_reg.spacing_y <= cfg_data[SP_W-1:0];
                CFG_Z:        cfg_reg.z_value   <= cfg_data;
                CFG_OUTLINE:  cfg_reg.outline   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // credit: every pixel in the two pipeline stages may still need a queue slot
    assign pending = (FCNT_W+1)'(fill) + (FCNT_W+1)'(s1.valid) + (FCNT_W+1)'(s2_valid);
    assign s_ready = pending < (FCNT_W+1)'(FIFO_DEPTH);
    assign accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    lbe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .label_in (s_feature_label[LABEL_BITS-1:0]),
        .cfg      (cfg_reg),
        .s1       (s1),
        .up_label (up_label)
    );

    lbe_coord u_coord (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1       (s1),
        .up_label (up_label),
        .cfg      (cfg_reg),
        .s2_valid (s2_valid),
        .push     (push),
        .push_seg (push_seg)
    );

    lbe_seg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_seg  (push_seg),
        .out_ready (m_ready),
        .fill      (fill),
        .out_valid (m_valid),
        .out_sx    (m_start_x),
        .out_sy    (m_start_y),
        .out_ex    (m_end_x),
        .out_ey    (m_end_y),
        .out_kind  (out_kind),
        .out_last  (m_last_of_pixel)
    );

    assign m_edge_kind = out_kind;
    assign m_plane_z   = cfg_reg.z_value;

endmodule

`default_nettype wire

FILE: tb/label_boundary_edge_extractor_checker.sv
// Scoreboard for the label boundary edge extractor: watches the pixel, segment and
// register channels, predicts the segments of every accepted pixel and compares them.
// Depends on lbe_pkg for the edge kind and register index codes.
module label_boundary_edge_extractor_checker import lbe_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [31:0]          s_feature_label,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic signed [31:0]   m_start_x,
    input  wire logic signed [31:0]   m_start_y,
    input  wire logic signed [31:0]   m_end_x,
    input  wire logic signed [31:0]   m_end_y,
    input  wire logic signed [31:0]   m_plane_z,
    input  wire logic [2:0]           m_edge_kind,
    input  wire logic                 m_last_of_pixel,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output int                        mismatch_count,
    output int                        pending_segs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] z;
        edge_kind_t         kind;
        logic               last;
    } boundary_seg_t;

    boundary_seg_t      seg_q [$];
    logic [31:0]        prev_row_lbl [MAX_WIDTH];
    logic [31:0]        left_lbl;
    int unsigned        col_pos;
    int unsigned        row_pos;

    logic [10:0]        r_width;
    logic [15:0]        r_height;
    logic signed [31:0] r_org_x;
    logic signed [31:0] r_org_y;
    logic [30:0]        r_pitch_x;
    logic [30:0]        r_pitch_y;
    logic signed [31:0] r_z;
    logic               r_outline;

    function automatic logic signed [31:0] grid_coord(
        input logic signed [31:0] org,
        input int unsigned        idx,
        input logic [30:0]        pitch
    );
        longint acc;
        acc = longint'(org) + longint'(idx) * longint'({1'b0, pitch});
        if (acc > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (acc < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return acc[31:0];
    endfunction

    function automatic boundary_seg_t make_seg(
        input int unsigned gx0,
        input int unsigned gy0,
        input int unsigned gx1,
        input int unsigned gy1,
        input edge_kind_t  kind
    );
        boundary_seg_t s;
        s.sx   = grid_coord(r_org_x, gx0, r_pitch_x);
        s.sy   = grid_coord(r_org_y, gy0, r_pitch_y);
        s.ex   = grid_coord(r_org_x, gx1, r_pitch_x);
        s.ey   = grid_coord(r_org_y, gy1, r_pitch_y);
        s.z    = r_z;
        s.kind = kind;
        s.last = 1'b0;
        return s;
    endfunction

    task automatic predict_pixel(input logic [31:0] lbl);
        int unsigned   w;
        int unsigned   h;
        int unsigned   x;
        int unsigned   y;
        int            n;
        boundary_seg_t segs [4];
        w = r_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = r_height;
        if (h == 0) h = 1;
        x = (col_pos < w) ? col_pos : w - 1;
        y = (row_pos < h) ? row_pos : h - 1;
        n = 0;
        if (x > 0 && left_lbl != lbl) begin
            segs[n] = make_seg(x, y, x, y + 1, EK_INT_V);
            n++;
        end
        if (y > 0 && prev_row_lbl[x] != lbl) begin
            segs[n] = make_seg(x, y, x + 1, y, EK_INT_H);
            n++;
        end
        if (r_outline) begin
            if (x == 0) begin
                segs[n] = make_seg(0, y, 0, y + 1, EK_LEFT);
                n++;
            end
            if (x == w - 1) begin
                segs[n] = make_seg(w, y, w, y + 1, EK_RIGHT);
                n++;
            end
            if (y == 0) begin
                segs[n] = make_seg(x, 0, x + 1, 0, EK_BOTTOM);
                n++;
            end
            if (y == h - 1) begin
                segs[n] = make_seg(x, h, x + 1, h, EK_TOP);
                n++;
            end
        end
        if (n > 0) segs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            seg_q.push_back(segs[i]);
        end
        prev_row_lbl[x] = lbl;
        left_lbl = lbl;
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %08h, got %08h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        boundary_seg_t exp_seg;
        if (!aresetn) begin
            r_width   = 11'd1;
            r_height  = 16'd1;
            r_org_x   = '0;
            r_org_y   = '0;
            r_pitch_x = 31'd65536;
            r_pitch_y = 31'd65536;
            r_z       = '0;
            r_outline = 1'b0;
            left_lbl  = '0;
            col_pos   = 0;
            row_pos   = 0;
            seg_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:    r_width   = cfg_data[10:0];
                    CFG_HEIGHT:   r_height  = cfg_data[15:0];
                    CFG_ORIGIN_X: r_org_x   = cfg_data;
                    CFG_ORIGIN_Y: r_org_y   = cfg_data;
                    CFG_SPACE_X:  r_pitch_x = cfg_data[30:0];
                    CFG_SPACE_Y:  r_pitch_y = cfg_data[30:0];
                    CFG_Z:        r_z       = cfg_data;
                    CFG_OUTLINE:  r_outline = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (seg_q.size() == 0) begin
                    $error("segment output with no pixel request waiting for it");
                    mismatch_count++;
                end else begin
                    exp_seg = seg_q.pop_front();
                    check_field("start_x", exp_seg.sx, m_start_x);
                    check_field("start_y", exp_seg.sy, m_start_y);
                    check_field("end_x", exp_seg.ex, m_end_x);
                    check_field("end_y", exp_seg.ey, m_end_y);
                    check_field("plane_z", exp_seg.z, m_plane_z);
                    check_field("edge_kind", 32'(exp_seg.kind), 32'(m_edge_kind));
                    check_field("last_of_pixel", 32'(exp_seg.last), 32'(m_last_of_pixel));
                end
            end
            if (s_valid && s_ready) begin
                predict_pixel(s_feature_label);
            end
        end
        pending_segs <= seg_q.size();
    end

endmodule

FILE: tb/label_boundary_edge_extractor_core_tb.sv
// Top of the label boundary edge extractor testbench: clock, reset, pixel and register
// stimulus, output back-pressure and the verdict. Needs lbe_pkg, the core and the checker.
module label_boundary_edge_extractor_core_tb;
    import lbe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [31:0]              s_feature_label = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [CRD_W-1:0]  m_start_x;
    logic signed [CRD_W-1:0]  m_start_y;
    logic signed [CRD_W-1:0]  m_end_x;
    logic signed [CRD_W-1:0]  m_end_y;
    logic signed [CRD_W-1:0]  m_plane_z;
    logic [2:0]               m_edge_kind;
    logic                     m_last_of_pixel;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [2:0]               cfg_index = CFG_WIDTH;
    logic [31:0]              cfg_data = '0;

    int                       mismatch_count;
    int                       pending_segs;

    int                       send_pct = 0;
    int                       recv_pct = 0;
    logic                     hold_tog = 1'b0;
    logic                     hold_seen = 1'b0;
    int                       hold_left = 0;

    int unsigned              cur_w = 1;
    int unsigned              cur_h = 1;
    int unsigned              col = 0;
    int unsigned              row = 0;
    logic [31:0]              last_lbl = '0;
    logic [31:0]              above [MAX_WIDTH];
    logic [31:0]              palette [4];

    label_boundary_edge_extractor_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_feature_label (s_feature_label),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_x       (m_start_x),
        .m_start_y       (m_start_y),
        .m_end_x         (m_end_x),
        .m_end_y         (m_end_y),
        .m_plane_z       (m_plane_z),
        .m_edge_kind     (m_edge_kind),
        .m_last_of_pixel (m_last_of_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    label_boundary_edge_extractor_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_feature_label (s_feature_label),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_x       (m_start_x),
        .m_start_y       (m_start_y),
        .m_end_x         (m_end_x),
        .m_end_y         (m_end_y),
        .m_plane_z       (m_plane_z),
        .m_edge_kind     (m_edge_kind),
        .m_last_of_pixel (m_last_of_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_segs    (pending_segs)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // segment back-pressure; a long hold is started by toggling hold_tog
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_WIDTH) cur_w = val[10:0];
        if (idx == CFG_HEIGHT) cur_h = val[15:0];
    endtask

    task automatic load_regs(
        input logic [31:0] w, input logic [31:0] h,
        input logic [31:0] ox, input logic [31:0] oy,
        input logic [31:0] sx, input logic [31:0] sy,
        input logic [31:0] z, input logic [31:0] ol
    );
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_SPACE_X, sx);
        write_reg(CFG_SPACE_Y, sy);
        write_reg(CFG_Z, z);
        write_reg(CFG_OUTLINE, ol);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_segments();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_segs != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // board = 1 gives a checkerboard of all-zero and all-one labels
    task automatic feed_pixel(input bit board);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned roll;
        logic [31:0] lbl;
        w = (cur_w == 0) ? 1 : ((cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w);
        h = (cur_h == 0) ? 1 : cur_h;
        x = (col < w) ? col : w - 1;
        y = (row < h) ? row : h - 1;
        roll = $urandom_range(0, 99);
        if (board) lbl = ((x ^ y) & 1) ? 32'hFFFF_FFFF : 32'h0;
        else if (roll < 30) lbl = last_lbl;
        else if (roll < 55) lbl = above[x];
        else if (roll < 90) lbl = palette[$urandom_range(0, 3)];
        else lbl = $urandom;
        while ($urandom_range(0, 99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_feature_label <= lbl;
        do @(posedge aclk); while (!s_ready);
        above[x] = lbl;
        last_lbl = lbl;
        if (x + 1 >= w) begin
            col = 0;
            row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col = x + 1;
            row = y;
        end
    endtask

    // finish the row, then cut the image short by shrinking height to one row
    task automatic close_image();
        while (col != 0) feed_pixel(1'b0);
        if (row != 0) begin
            drain_segments();
            write_reg(CFG_HEIGHT, 32'd1);
            cfg_valid <= 1'b0;
            do feed_pixel(1'b0); while (col != 0 || row != 0);
        end
    endtask

    function automatic logic [31:0] pick_origin();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2: return 32'h7FF0_0000 + 32'($urandom_range(0, 32'h000F_FFFF));
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_pitch();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h0001_0000;
            2: return 32'h0;
            default: return 32'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    task automatic run_phase(input int snd, input int rcv, input int n_px,
                             input bit squeeze, input bit widest);
        logic [31:0] w_val;
        logic [31:0] h_val;
        logic [31:0] ol_val;
        int          roll;
        drain_segments();
        roll = $urandom_range(0, 99);
        if (widest) w_val = 32'd2047;
        else if (roll < 6) w_val = 32'd0;
        else if (roll < 12) w_val = 32'd1;
        else w_val = $urandom_range(2, 12);
        roll = $urandom_range(0, 99);
        if (widest) h_val = 32'd1;
        else if (roll < 6) h_val = 32'd0;
        else if (roll < 12) h_val = 32'd65535;
        else h_val = $urandom_range(1, 6);
        ol_val = (squeeze || widest) ? 32'd1 : 32'($urandom_range(0, 1));
        w_val  = w_val | ($urandom & 32'hFFFF_F800);
        h_val  = h_val | ($urandom & 32'hFFFF_0000);
        ol_val = ol_val | ($urandom & 32'hFFFF_FFFE);
        palette[0] = 32'h0;
        palette[1] = 32'hFFFF_FFFF;
        palette[2] = $urandom;
        palette[3] = $urandom;
        load_regs(w_val, h_val, pick_origin(), pick_origin(), pick_pitch(), pick_pitch(),
                  $urandom, ol_val);
        send_pct = snd;
        recv_pct = rcv;
        for (int i = 0; i < n_px; i++) begin
            feed_pixel(1'b0);
            if (squeeze && i == 10) hold_tog <= ~hold_tog;
        end
        // end the wide row early: the current column becomes the last one
        if (widest && col != 0) begin
            drain_segments();
            write_reg(CFG_WIDTH, 32'(col + 1));
            cfg_valid <= 1'b0;
        end
        close_image();
    endtask

    initial begin
        foreach (above[i]) above[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one-pixel image without outline, no segments
        feed_pixel(1'b1);
        feed_pixel(1'b1);
        drain_segments();

        load_regs(32'd3, 32'd3, 32'hFFFD_0000, 32'h0000_8000, 32'h0001_0000,
                  32'h8002_0000, 32'hDEAD_BEEF, 32'd1);
        repeat (9) feed_pixel(1'b1);
        drain_segments();

        // zero width and height, saturating coordinates
        load_regs(32'hFFFF_F800, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1);
        feed_pixel(1'b1);
        drain_segments();

        // zero pitch
        load_regs(32'd2, 32'd1, 32'h0012_3456, 32'hFFED_CBAA, 32'h0, 32'h0,
                  32'h0000_0001, 32'd1);
        repeat (2) feed_pixel(1'b1);
        drain_segments();

        // shrink width and then height while the position is past them
        load_regs(32'd4, 32'd3, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'd1);
        repeat (6) feed_pixel(1'b1);
        drain_segments();
        write_reg(CFG_WIDTH, 32'd2);
        cfg_valid <= 1'b0;
        feed_pixel(1'b1);
        drain_segments();
        write_reg(CFG_HEIGHT, 32'd2);
        cfg_valid <= 1'b0;
        repeat (2) feed_pixel(1'b1);

        run_phase(0, 0, 44, 1'b1, 1'b0);
        run_phase(88, 0, 44, 1'b0, 1'b0);
        run_phase(0, 88, 44, 1'b0, 1'b0);
        run_phase(29, 29, 44, 1'b0, 1'b0);
        run_phase(0, 0, 44, 1'b0, 1'b0);
        run_phase(88, 0, 44, 1'b0, 1'b0);
        run_phase(0, 88, 44, 1'b0, 1'b0);
        run_phase(29, 29, 44, 1'b0, 1'b0);
        run_phase(0, 0, 40, 1'b0, 1'b1);
        drain_segments();

        if (mismatch_count == 0 && pending_segs == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/lbe_pkg.sv
sv/lbe_front.sv
sv/lbe_coord.sv
sv/lbe_seg_queue.sv
sv/label_boundary_edge_extractor_core.sv
tb/label_boundary_edge_extractor_checker.sv
tb/label_boundary_edge_extractor_core_tb.sv
